// File: rtl/dhks_pkg.sv
// ----------------------------------------------------------------------------
// dhks_pkg
// Shared constants, codes and command/status types for the key set.
// ----------------------------------------------------------------------------
package dhks_pkg;
  localparam int SlotBits = 12;
  localparam int TableSlots = 1 << SlotBits;
  localparam int ProbeLimit = 10;
  localparam int ProbeBits = $clog2(ProbeLimit + 1);

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_USED = 2'd1;
  localparam logic [1:0] TAG_DEAD = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOCHG = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load;      // latch key, start digit extraction
    logic digit;     // extract one decimal digit
    logic hash;      // fold one character into both hashes
    logic fold;      // reduce second hash to step remainder
    logic home;      // set probe index to home
    logic rd;        // issue memory read at index
    logic adv;       // index += step
    logic wr_used;   // write key and USED tag at index
    logic wr_dead;   // write DEAD tag at index
    logic mark_free; // remember index as first free slot
    logic use_free;  // set index to remembered free slot
    logic clr;       // empty one slot of the clearing pass
  } dhks_cmd_t;

  typedef struct packed {
    logic digits_done;
    logic chars_done;
    logic [1:0] tag;
    logic key_match;
    logic clr_done;
  } dhks_stat_t;
endpackage

// File: rtl/dhks_datapath.sv
// ----------------------------------------------------------------------------
// dhks_datapath
// Decimal text, djb2/sdbm hashes, modulo reduction and the slot memories.
// ----------------------------------------------------------------------------
module dhks_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        key,
  input  dhks_pkg::dhks_cmd_t cmd,
  output dhks_pkg::dhks_stat_t stat
);
  import dhks_pkg::*;

  localparam int Chunks = (32 + SlotBits - 1) / SlotBits;
  localparam int ExtBits = SlotBits * Chunks;
  localparam int SumBits = SlotBits + 4;
  localparam int FoldBits = SlotBits + 1;

  logic [31:0] key_q;
  logic [31:0] mag;
  logic [3:0] digs [10];
  logic [3:0] nd;
  logic [3:0] ci;
  logic [3:0] nchars;
  logic neg;
  logic [31:0] ha;
  logic [31:0] hb;
  logic [SlotBits-1:0] rem;
  logic [SlotBits-1:0] idx;
  logic [SlotBits-1:0] step;
  logic [SlotBits-1:0] free_idx;
  logic [SlotBits-1:0] clr_addr;
  logic [SlotBits-1:0] wr_addr;
  logic [1:0] wr_tag;
  logic wr_en;
  logic [1:0] tag_rd;
  logic [31:0] key_rd;
  logic [1:0] tag_mem [TableSlots];
  logic [31:0] key_mem [TableSlots];
  logic [7:0] ch;
  logic [35:0] q_prod;
  logic [31:0] q;
  logic [3:0] r;
  logic [ExtBits-1:0] hb_ext;
  logic [SumBits-1:0] chunk_sum;
  logic [FoldBits-1:0] fold_sum;
  logic [SlotBits-1:0] step_mod;

  // mag / 10 via reciprocal: q = (mag * 0xCCCCCCCD) >> 35 needs 64b; one 64-bit product
  logic [63:0] q_full;
  assign q_full = {32'd0, mag} * 64'hCCCCCCCD;
  assign q = {3'd0, q_full[63:35]};
  assign q_prod = {q, 2'b00} + {4'd0, q};
  assign r = 4'(mag - {q_prod[30:0], 1'b0});

  always_comb begin
    if (neg && ci == 4'd0) begin
      ch = 8'h2D;
    end else begin
      ch = 8'h30 + {4'd0, digs[4'(nd - 4'd1 - (ci - {3'd0, neg}))]};
    end
  end

  // fold slot-width chunks of hb; 2^SlotBits is 1 modulo TableSlots-1
  always_comb begin
    hb_ext = ExtBits'(hb);
    chunk_sum = '0;
    for (int i = 0; i < Chunks; i++) begin
      chunk_sum = chunk_sum + SumBits'(hb_ext[i*SlotBits +: SlotBits]);
    end
    fold_sum = FoldBits'(chunk_sum[SlotBits-1:0]) +
               FoldBits'(chunk_sum[SumBits-1:SlotBits]);
    if (fold_sum >= FoldBits'(TableSlots - 1)) begin
      step_mod = SlotBits'(fold_sum - FoldBits'(TableSlots - 1));
    end else begin
      step_mod = fold_sum[SlotBits-1:0];
    end
  end

  assign wr_en = cmd.clr || cmd.wr_used || cmd.wr_dead;
  assign wr_addr = cmd.clr ? clr_addr : idx;
  assign wr_tag = cmd.clr ? TAG_EMPTY : (cmd.wr_used ? TAG_USED : TAG_DEAD);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= key;
      neg <= key[31];
      mag <= key[31] ? (32'd0 - key) : key;
      nd <= 4'd0;
      ci <= 4'd0;
      ha <= 32'd5381;
      hb <= 32'd0;
    end
    if (cmd.digit) begin
      digs[nd] <= r;
      nd <= nd + 4'd1;
      mag <= q;
    end
    if (cmd.hash) begin
      ha <= (ha << 5) + ha + {24'd0, ch};
      hb <= {24'd0, ch} + (hb << 6) + (hb << 16) - hb;
      ci <= ci + 4'd1;
    end
    if (cmd.fold) rem <= step_mod;
    if (cmd.home) begin
      idx <= ha[SlotBits-1:0];
      step <= rem | {{(SlotBits-1){1'b0}}, 1'b1};
    end
    if (cmd.adv) idx <= idx + step;
    if (cmd.mark_free) free_idx <= idx;
    if (cmd.use_free) idx <= free_idx;
    if (cmd.rd) begin
      tag_rd <= tag_mem[idx];
      key_rd <= key_mem[idx];
    end
    if (wr_en) tag_mem[wr_addr] <= wr_tag;
    if (cmd.wr_used) key_mem[idx] <= key_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign nchars = nd + {3'd0, neg};
  assign stat.digits_done = (nd != 4'd0 && mag == 32'd0) || (nd == 4'd10);
  assign stat.chars_done = (ci == nchars);
  assign stat.tag = tag_rd;
  assign stat.key_match = (key_rd == key_q);
  assign stat.clr_done = (clr_addr == {SlotBits{1'b1}});
endmodule

// File: rtl/dhks_ctrl.sv
// ----------------------------------------------------------------------------
// dhks_ctrl
// Sequencer: clearing, text, hash, reduce, locate, insert or remove and result handshake.
// ----------------------------------------------------------------------------
module dhks_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 found,
  output logic [1:0]           status,
  output dhks_pkg::dhks_cmd_t  cmd,
  input  dhks_pkg::dhks_stat_t stat
);
  import dhks_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIG = 4'd1;
  localparam logic [3:0] S_HASH = 4'd2;
  localparam logic [3:0] S_MOD = 4'd3;
  localparam logic [3:0] S_HOME = 4'd4;
  localparam logic [3:0] S_LRD = 4'd5;
  localparam logic [3:0] S_LCHK = 4'd6;
  localparam logic [3:0] S_ARD = 4'd7;
  localparam logic [3:0] S_ACHK = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_CLR = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] op;
  logic [ProbeBits-1:0] probe;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_DIG;
      end
      S_DIG: begin
        cmd.digit = 1'b1;
        if (stat.digits_done) begin
          cmd.digit = 1'b0;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.chars_done) state_next = S_MOD;
        else cmd.hash = 1'b1;
      end
      S_MOD: begin
        cmd.fold = 1'b1;
        state_next = S_HOME;
      end
      S_HOME: begin
        cmd.home = 1'b1;
        state_next = S_LRD;
      end
      S_LRD: begin
        cmd.rd = 1'b1;
        state_next = S_LCHK;
      end
      S_LCHK: begin
        if (stat.tag == TAG_USED && stat.key_match) begin
          if (op == CMD_REMOVE) cmd.wr_dead = 1'b1;
          state_next = S_OUT;
        end else if (stat.tag == TAG_EMPTY ||
                     probe == ProbeBits'(ProbeLimit - 1)) begin
          if (op == CMD_ADD) begin
            cmd.home = 1'b1;
            state_next = S_ARD;
          end else begin
            state_next = S_OUT;
          end
        end else begin
          cmd.adv = 1'b1;
          state_next = S_LRD;
        end
      end
      S_ARD: begin
        cmd.rd = 1'b1;
        state_next = S_ACHK;
      end
      S_ACHK: begin
        if (stat.tag != TAG_USED) begin
          cmd.wr_used = 1'b1;
          state_next = S_OUT;
        end else if (probe == ProbeBits'(ProbeLimit - 1)) begin
          state_next = S_OUT;
        end else begin
          cmd.adv = 1'b1;
          state_next = S_ARD;
        end
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      op <= CMD_ADD;
      probe <= '0;
      found <= 1'b0;
      status <= ST_NOCHG;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (in_valid) begin
          op <= in_cmd;
          probe <= '0;
        end
        S_HOME: probe <= '0;
        S_LCHK: begin
          if (stat.tag == TAG_USED && stat.key_match) begin
            found <= (op inside {CMD_ADD, CMD_REMOVE, CMD_FIND});
            status <= (op == CMD_ADD) ? ST_NOCHG :
                      (op == CMD_REMOVE || op == CMD_FIND) ? ST_OK : ST_NOCHG;
          end else if (stat.tag == TAG_EMPTY ||
                       probe == ProbeBits'(ProbeLimit - 1)) begin
            found <= 1'b0;
            status <= (op == CMD_FIND) ? ST_OK : ST_NOCHG;
            probe <= '0;
          end else begin
            probe <= probe + 1'b1;
          end
        end
        S_ACHK: begin
          if (stat.tag != TAG_USED) status <= ST_OK;
          else if (probe == ProbeBits'(ProbeLimit - 1)) status <= ST_FULL;
          else probe <= probe + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/double_hash_key_set_top.sv
// Sequence from input beat to result valid: digit extraction, hashing of each character,
// reduction and loading of home, then a read and a check per probe, up to 10 probes to
// look up and up to 10 more to add. Flow: one beat in flight; the next input beat is
// taken in the cycle after the result beat is accepted.
// Reset: synchronous; a clearing pass then empties every slot while the input stalls.
// ----------------------------------------------------------------------------
// double_hash_key_set_top
// Open-addressed key set with double hashing over decimal key text.
// ----------------------------------------------------------------------------
module double_hash_key_set_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic signed [31:0] key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [1:0]  status
);
  import dhks_pkg::*;

  dhks_cmd_t  dp_cmd;
  dhks_stat_t dp_stat;

  dhks_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(cmd), .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .status(status), .cmd(dp_cmd), .stat(dp_stat)
  );

  dhks_datapath u_dp (
    .clk(clk), .rst(rst), .key(key), .cmd(dp_cmd), .stat(dp_stat)
  );
endmodule

// File: rtl/dhks_checker.sv
// ----------------------------------------------------------------------------
// dhks_checker
// Port-level checks on the key set's handshakes and results.
// ----------------------------------------------------------------------------
module dhks_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       found,
  input logic [1:0] status
);
  import dhks_pkg::*;

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(status))
    else $error("result changed while stalled");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NOCHG || status == ST_FULL))
    else $error("bad status");
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> !found) else $error("full with found");
endmodule

bind double_hash_key_set_top dhks_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .found(found), .status(status)
);
